// ----- hw/rtl/strm_pkg.sv -----
// ----------------------------------------------------------------------------
// strm_pkg
// Shared types, constants and helpers of the sparse-table range-minimum engine.
// ----------------------------------------------------------------------------
package strm_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVELS       = 11;

    localparam int KEY_W   = 32;
    localparam int TAG_W   = 16;
    localparam int PAIR_W  = KEY_W + TAG_W;
    localparam int LEFT_W  = 10;
    localparam int RIGHT_W = 11;

    localparam int POS_W  = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int LVL_W  = $clog2(LEVELS + 1);
    localparam int LOG_W  = $clog2(RIGHT_W);
    localparam int DEPTH  = LEVELS * MAX_ELEMENTS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic [PAIR_W-1:0] t_pair;

    typedef struct packed {
        logic               kind;
        logic [KEY_W-1:0]   elem_key;
        logic [TAG_W-1:0]   elem_tag;
        logic               load_last;
        logic [LEFT_W-1:0]  range_left;
        logic [RIGHT_W-1:0] range_right;
    } t_in;

    typedef struct packed {
        logic [KEY_W-1:0] min_key;
        logic [TAG_W-1:0] min_tag;
        logic             range_error;
    } t_out;

    typedef struct packed {
        logic             built;
        logic [CNT_W-1:0] count;
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
    } t_rd_req;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_pair             wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } t_ram_req;

    // key first, then tag: plain compare of the packed pair
    function automatic t_pair pair_min(input t_pair a, input t_pair b);
        return (b < a) ? b : a;
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [LVL_W-1:0] lvl,
                                                  input logic [POS_W-1:0] pos);
        return ADDR_W'({lvl, pos});
    endfunction

    function automatic logic [LOG_W-1:0] floor_log2(input logic [RIGHT_W-1:0] v);
        logic [LOG_W-1:0] r;
        r = '0;
        for (int i = 0; i < RIGHT_W; i++) begin
            if (v[i]) r = LOG_W'(i);
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/strm_ram.sv -----
// ----------------------------------------------------------------------------
// strm_ram
// Simple RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module strm_ram #(
    parameter int DATA_W = 48,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- hw/rtl/strm_query.sv -----
// ----------------------------------------------------------------------------
// strm_query
// Query path: range check, window addresses, minimum of the two reads.
// ----------------------------------------------------------------------------
module strm_query (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  strm_pkg::t_in     i_item,
    input  logic              i_accept,
    input  strm_pkg::t_status i_status,
    input  strm_pkg::t_pair   i_rdata_a,
    input  strm_pkg::t_pair   i_rdata_b,
    output strm_pkg::t_rd_req o_rd_req,
    output strm_pkg::t_out    o_result,
    output logic              o_valid
);

    logic [strm_pkg::RIGHT_W-1:0] len;
    logic [strm_pkg::LOG_W-1:0]   lg;
    logic [strm_pkg::RIGHT_W-1:0] span;
    logic [strm_pkg::RIGHT_W-1:0] pos_b;
    logic                         err;
    logic                         qry_acc;

    logic           r_q_valid;
    logic           r_q_err;
    logic           r_valid;
    strm_pkg::t_out r_result;
    strm_pkg::t_out n_result;
    strm_pkg::t_pair m;

    assign qry_acc = i_accept && (i_item.kind == strm_pkg::KIND_QUERY);
    assign len     = i_item.range_right - strm_pkg::RIGHT_W'(i_item.range_left);
    assign lg      = strm_pkg::floor_log2(len);
    assign span    = strm_pkg::RIGHT_W'(1) << lg;
    assign pos_b   = i_item.range_right - span;

    assign err = !i_status.built
              || (32'(i_item.range_left) >= 32'(i_item.range_right))
              || (32'(i_item.range_right) > 32'(i_status.count))
              || (32'(lg) >= strm_pkg::LEVELS);

    assign o_rd_req.addr_a = strm_pkg::addr_of(strm_pkg::LVL_W'(lg),
                                               strm_pkg::POS_W'(i_item.range_left));
    assign o_rd_req.addr_b = strm_pkg::addr_of(strm_pkg::LVL_W'(lg),
                                               pos_b[strm_pkg::POS_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_q_valid <= qry_acc;
            r_valid   <= r_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_err  <= err;
        r_result <= n_result;
    end

    assign m = strm_pkg::pair_min(i_rdata_a, i_rdata_b);

    always_comb begin
        if (r_q_err) begin
            n_result             = '0;
            n_result.range_error = 1'b1;
        end else begin
            n_result.min_key     = m[strm_pkg::PAIR_W-1:strm_pkg::TAG_W];
            n_result.min_tag     = m[strm_pkg::TAG_W-1:0];
            n_result.range_error = 1'b0;
        end
    end

    assign o_result = r_result;
    assign o_valid  = r_valid;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_valid |=> o_valid)
        else $error("query read did not produce a result");
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.range_error |-> (o_result.min_key == '0)
                                          && (o_result.min_tag == '0))
        else $error("rejected query carries a nonzero pair");
`endif

endmodule

// ----- hw/rtl/strm_ctrl.sv -----
// ----------------------------------------------------------------------------
// strm_ctrl
// Load bookkeeping, level build sequencer and memory port arbitration.
// ----------------------------------------------------------------------------
module strm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  strm_pkg::t_in      i_item,
    input  logic               i_accept,
    input  strm_pkg::t_rd_req  i_qry_req,
    input  strm_pkg::t_pair    i_rdata_a,
    input  strm_pkg::t_pair    i_rdata_b,
    output logic               o_busy,
    output strm_pkg::t_status  o_status,
    output strm_pkg::t_ram_req o_ram
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_BUILD = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [strm_pkg::CNT_W-1:0]  r_count, n_count;
    logic                        r_built, n_built;
    logic [strm_pkg::LVL_W-1:0]  r_lvl, n_lvl;
    logic [strm_pkg::POS_W-1:0]  r_idx, n_idx;
    logic                        r_wr_pend, n_wr_pend;
    logic [strm_pkg::ADDR_W-1:0] r_wr_addr, n_wr_addr;

    logic                        load_acc;
    logic [strm_pkg::CNT_W-1:0]  base;
    logic                        room;
    logic [strm_pkg::CNT_W:0]    span;
    logic [strm_pkg::CNT_W:0]    half;
    logic [strm_pkg::CNT_W:0]    last_idx;
    logic [strm_pkg::ADDR_W-1:0] bld_addr_a;
    logic [strm_pkg::ADDR_W-1:0] bld_addr_b;

    assign load_acc = i_accept && (i_item.kind == strm_pkg::KIND_LOAD);
    assign base     = r_built ? '0 : r_count;
    assign room     = 32'(base) < strm_pkg::MAX_ELEMENTS;
    assign span     = (strm_pkg::CNT_W + 1)'(1) << r_lvl;
    assign half     = span >> 1;
    assign last_idx = {1'b0, r_count} - span;

    // level d entry i is the min of level d-1 entries i and i + 2^(d-1)
    assign bld_addr_a = strm_pkg::addr_of(r_lvl - strm_pkg::LVL_W'(1), r_idx);
    assign bld_addr_b = strm_pkg::addr_of(r_lvl - strm_pkg::LVL_W'(1),
                                          r_idx + half[strm_pkg::POS_W-1:0]);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_built   = r_built;
        n_lvl     = r_lvl;
        n_idx     = r_idx;
        n_wr_pend = 1'b0;
        n_wr_addr = strm_pkg::addr_of(r_lvl, r_idx);
        unique case (r_state)
            ST_IDLE: begin
                if (load_acc) begin
                    n_built = 1'b0;
                    n_count = room ? base + strm_pkg::CNT_W'(1) : base;
                    if (i_item.load_last) begin
                        n_state = ST_CHECK;
                        n_lvl   = strm_pkg::LVL_W'(1);
                    end
                end
            end
            ST_CHECK: begin
                // doubles as the gap that lets the last write of a level land
                if ((32'(r_lvl) >= strm_pkg::LEVELS) || (span > {1'b0, r_count})) begin
                    n_built = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_idx   = '0;
                    n_state = ST_BUILD;
                end
            end
            ST_BUILD: begin
                n_wr_pend = 1'b1;
                if (r_idx == last_idx[strm_pkg::POS_W-1:0]) begin
                    n_lvl   = r_lvl + strm_pkg::LVL_W'(1);
                    n_state = ST_CHECK;
                end else begin
                    n_idx = r_idx + strm_pkg::POS_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_built   <= 1'b0;
            r_lvl     <= '0;
            r_idx     <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_built   <= n_built;
            r_lvl     <= n_lvl;
            r_idx     <= n_idx;
            r_wr_pend <= n_wr_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= n_wr_addr;
    end

    always_comb begin
        o_ram.we      = r_wr_pend || (load_acc && room);
        if (r_wr_pend) begin
            o_ram.waddr = r_wr_addr;
            o_ram.wdata = strm_pkg::pair_min(i_rdata_a, i_rdata_b);
        end else begin
            o_ram.waddr = strm_pkg::addr_of('0, base[strm_pkg::POS_W-1:0]);
            o_ram.wdata = {i_item.elem_key, i_item.elem_tag};
        end
        if (r_state == ST_IDLE) begin
            o_ram.raddr_a = i_qry_req.addr_a;
            o_ram.raddr_b = i_qry_req.addr_b;
        end else begin
            o_ram.raddr_a = bld_addr_a;
            o_ram.raddr_b = bld_addr_b;
        end
    end

    assign o_busy         = r_state != ST_IDLE;
    assign o_status.built = r_built;
    assign o_status.count = r_count;

`ifndef SYNTHESIS
    a_pend_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pend |-> (r_state != ST_IDLE))
        else $error("level write pending while idle");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= strm_pkg::MAX_ELEMENTS)
        else $error("element count past capacity");
    a_build_unbuilt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BUILD) |-> !r_built)
        else $error("table marked built during level build");
`endif

endmodule

// ----- hw/rtl/sparse_table_range_min_top.sv -----
// ----------------------------------------------------------------------------
// sparse_table_range_min_top
// Range-minimum engine over (key, tag) pairs with a power-of-two level table.
// ----------------------------------------------------------------------------
//
//  channel   ports                        direction  handshake
//  -------   --------------------------   ---------  -------------------------
//  item      start, busy, i_item          in         transfer when start & !busy
//  result    o_valid, o_result            out        one-cycle strobe, no stall
//
//  loads and queries are taken one per cycle while busy is low
//  a query result strobes after the RAM read register and the result register; loads give no result
//  after an element marked last, busy stays high for the level build: each level
//    is checked, and each level d that fits gets (count - 2^d + 1) entries, written
//    one at a time through the single write port of the level table
//  reset clears count, built flag and control; the table itself needs no clear
//  the receiver cannot stall, so results never back up into the engine
//
module sparse_table_range_min_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  strm_pkg::t_in  i_item,
    output logic           busy,
    output strm_pkg::t_out o_result,
    output logic           o_valid
);

    // input transfer
    logic               accept;
    // table status for the range check
    strm_pkg::t_status  status;
    // query window addresses
    strm_pkg::t_rd_req  qry_req;
    // memory port bundle from the controller
    strm_pkg::t_ram_req ram_req;
    // registered read data, shared by build and query
    strm_pkg::t_pair    rdata_a;
    strm_pkg::t_pair    rdata_b;

    assign accept = start && !busy;

    // loads, level build sequencing and port selection
    strm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_accept  (accept),
        .i_qry_req (qry_req),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b),
        .o_busy    (busy),
        .o_status  (status),
        .o_ram     (ram_req)
    );

    // range check, window lookup and the final compare
    strm_query u_query (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_accept  (accept),
        .i_status  (status),
        .i_rdata_a (rdata_a),
        .i_rdata_b (rdata_b),
        .o_rd_req  (qry_req),
        .o_result  (o_result),
        .o_valid   (o_valid)
    );

    // level table: level in the upper address bits, position in the lower
    strm_ram #(
        .DATA_W (strm_pkg::PAIR_W),
        .DEPTH  (strm_pkg::DEPTH),
        .ADDR_W (strm_pkg::ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_req.we),
        .i_waddr   (ram_req.waddr),
        .i_wdata   (ram_req.wdata),
        .i_raddr_a (ram_req.raddr_a),
        .i_raddr_b (ram_req.raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

endmodule
